// ===== hdl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared constants and types for the stable descending key sorter.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int unsigned MAX_ITEMS = 16;
    localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
    localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned TAG_W     = 4;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_EMIT
    } t_state;

endpackage

// ===== hdl/sks_store.sv =====
// ----------------------------------------------------------------------------
// sks_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sks_store (
    input  logic                         i_clk,
    input  sks_pkg::t_wr_req             i_wr,
    input  logic [sks_pkg::ADDR_W-1:0]   i_rd_addr,
    output sks_pkg::t_entry              o_rd_data
);
    import sks_pkg::*;

    t_entry r_mem [MAX_ITEMS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== hdl/stable_descending_key_sorter.sv =====
// ----------------------------------------------------------------------------
// stable_descending_key_sorter
// Collects a list of keyed entries and emits it sorted by key, largest first,
// with equal keys kept in arrival order. Entries beyond capacity are dropped
// and flagged on every result of that list.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     start (in), busy (out)         i_order_key, i_item_tag, i_last_in
//  result    o_valid strobe, one cycle      o_sorted_key, o_sorted_tag,
//                                           o_last_out, o_overflowed
//
//  An entry is transferred when start is high and busy is low. Inserting into
//  a list of stored entries walks the memory read port from the tail, one entry
//  at a time, and stops where the new key does not move past the entry read or
//  at the head. A list end then emits the stored entries, one read per cycle.
//  Reset is synchronous, active low, and empties the list; no clearing pass.
//  The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module stable_descending_key_sorter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sks_pkg::KEY_W-1:0]  i_order_key,
    input  logic [sks_pkg::TAG_W-1:0]         i_item_tag,
    input  logic                              i_last_in,
    output logic                              o_valid,
    output logic signed [sks_pkg::KEY_W-1:0]  o_sorted_key,
    output logic [sks_pkg::TAG_W-1:0]         o_sorted_tag,
    output logic                              o_last_out,
    output logic                              o_overflowed
);
    import sks_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    t_entry            r_new, n_new;
    logic              r_last, n_last;
    logic              r_oval, n_oval;
    logic              r_olast, n_olast;
    logic              r_oovf, n_oovf;

    t_wr_req           wr;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            rd_data;

    logic              accept;
    logic              full;
    logic              cnt_empty;
    logic              ins_at_head;
    logic              ins_shift;
    logic              ins_done;
    logic              emit_end;

    sks_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && (r_state == S_IDLE);
    assign full        = (r_cnt == CNT_W'(MAX_ITEMS));
    assign cnt_empty   = (r_cnt == '0);
    assign ins_at_head = (r_ptr == '0);
    assign ins_shift   = !ins_at_head && ($signed(rd_data.key) < $signed(r_new.key));
    assign ins_done    = (r_state == S_INS) && !ins_shift;
    assign emit_end    = (CNT_W'(r_ptr) + CNT_W'(1)) == r_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (full || cnt_empty) begin
                        n_state = i_last_in ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                if (ins_done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (emit_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_ptr   = r_ptr;
        n_new   = r_new;
        n_last  = r_last;
        n_oval  = 1'b0;
        n_olast = 1'b0;
        n_oovf  = r_oovf;
        wr      = '0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new.key = i_order_key;
                    n_new.tag = i_item_tag;
                    n_last    = i_last_in;
                    n_ptr     = '0;
                    if (full) begin
                        // drop the entry, remember it for this list
                        n_ovf = 1'b1;
                    end else if (cnt_empty) begin
                        wr.en       = 1'b1;
                        wr.addr     = '0;
                        wr.data.key = i_order_key;
                        wr.data.tag = i_item_tag;
                        n_cnt       = CNT_W'(1);
                    end else begin
                        // start the walk at the tail
                        n_ptr   = r_cnt[ADDR_W-1:0];
                        rd_addr = ADDR_W'(r_cnt - CNT_W'(1));
                    end
                end
            end
            S_INS: begin
                wr.en   = 1'b1;
                wr.addr = r_ptr;
                if (ins_shift) begin
                    // move the smaller entry down one place, read the next
                    wr.data = rd_data;
                    n_ptr   = r_ptr - ADDR_W'(1);
                    rd_addr = r_ptr - ADDR_W'(2);
                end else begin
                    wr.data = r_new;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_ptr   = '0;
                end
            end
            S_EMIT: begin
                rd_addr = r_ptr;
                n_oval  = 1'b1;
                n_oovf  = r_ovf;
                if (emit_end) begin
                    n_olast = 1'b1;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_ptr = r_ptr + ADDR_W'(1);
                end
            end
            default: begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_ptr   <= '0;
            r_oval  <= 1'b0;
            r_olast <= 1'b0;
            r_oovf  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ptr   <= n_ptr;
            r_oval  <= n_oval;
            r_olast <= n_olast;
            r_oovf  <= n_oovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new  <= n_new;
        r_last <= n_last;
    end

    assign o_valid      = r_oval;
    assign o_sorted_key = rd_data.key;
    assign o_sorted_tag = rd_data.tag;
    assign o_last_out   = r_olast;
    assign o_overflowed = r_oovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ITEMS))
        else $error("entry count beyond capacity");

    a_ins_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (CNT_W'(r_ptr) <= r_cnt) && !full)
        else $error("insert pointer outside the stored list");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_EMIT)
        else $error("result strobe outside an emit run");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_out) |=> o_valid)
        else $error("emit run broken before its last result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> o_valid && cnt_empty && !r_ovf)
        else $error("list not emptied after last result");

endmodule

// ===== sim/stable_descending_key_sorter_test.sv =====
// ----------------------------------------------------------------------------
// stable_descending_key_sorter_test
// Self-checking bench for the key sorter. Sends lists of keyed entries with
// random gaps, keeps a sorted copy of each list, and compares every emitted
// entry (key, tag, last flag, overflow flag) against that copy in order.
// ----------------------------------------------------------------------------
module stable_descending_key_sorter_test;

    import sks_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 360;
    localparam int MAX_GAP       = 11;
    localparam int DRAIN_CYCLES  = 48;
    localparam int PRINT_LIMIT   = 40;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
        logic                    ovf;
    } t_sorted_res;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
        bit                      typed;
        t_sorted_res             res;
    } t_stim_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [KEY_W-1:0] i_order_key;
    logic [TAG_W-1:0]        i_item_tag;
    logic                    i_last_in;
    logic                    o_valid;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic [TAG_W-1:0]        o_sorted_tag;
    logic                    o_last_out;
    logic                    o_overflowed;

    // sorted copy of the list being loaded
    logic signed [KEY_W-1:0] list_key [MAX_ITEMS];
    logic [TAG_W-1:0]        list_tag [MAX_ITEMS];
    int                      list_count;
    bit                      list_dropped;

    t_sorted_res pending_sorted[$];
    t_stim_row   directed_rows[$];

    int mismatch_count;
    int cycle_count;
    int lists_done;
    int overflow_lists;
    int results_seen;
    int entries_sent;

    stable_descending_key_sorter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_order_key  (i_order_key),
        .i_item_tag   (i_item_tag),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .o_sorted_key (o_sorted_key),
        .o_sorted_tag (o_sorted_tag),
        .o_last_out   (o_last_out),
        .o_overflowed (o_overflowed)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_sorted.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    // Insert one accepted entry into the sorted copy; on a list end queue the run.
    task automatic sort_accept(input logic signed [KEY_W-1:0] key,
                               input logic [TAG_W-1:0] tag, input logic last,
                               input bit typed, input t_sorted_res typed_res);
        int pos;
        t_sorted_res r;
        if (list_count < MAX_ITEMS) begin
            pos = 0;
            // equal keys stay ahead of the newcomer
            while (pos < list_count && !(list_key[pos] < key)) pos++;
            for (int k = list_count; k > pos; k--) begin
                list_key[k] = list_key[k-1];
                list_tag[k] = list_tag[k-1];
            end
            list_key[pos] = key;
            list_tag[pos] = tag;
            list_count++;
        end else begin
            list_dropped = 1'b1;
        end
        if (last) begin
            if (typed) begin
                pending_sorted.push_back(typed_res);
            end else begin
                for (int k = 0; k < list_count; k++) begin
                    r.key  = list_key[k];
                    r.tag  = list_tag[k];
                    r.last = (k == list_count - 1);
                    r.ovf  = list_dropped;
                    pending_sorted.push_back(r);
                end
            end
            lists_done++;
            if (list_dropped) overflow_lists++;
            list_count   = 0;
            list_dropped = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_entry(input logic signed [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag, input logic last,
                              input int gap, input bit typed, input t_sorted_res typed_res);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_order_key = key;
        i_item_tag  = tag;
        i_last_in   = last;
        do @(posedge i_clk); while (busy);
        sort_accept(key, tag, last, typed, typed_res);
        entries_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_sorted_res want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_sorted.size() == 0) begin
                report_mismatch("unexpected result, key", o_sorted_key, '0);
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_key !== want.key)
                    report_mismatch("sorted_key", o_sorted_key, want.key);
                if (o_sorted_tag !== want.tag)
                    report_mismatch("sorted_tag", KEY_W'(o_sorted_tag), KEY_W'(want.tag));
                if (o_last_out !== want.last)
                    report_mismatch("last_out", KEY_W'(o_last_out), KEY_W'(want.last));
                if (o_overflowed !== want.ovf)
                    report_mismatch("overflowed", KEY_W'(o_overflowed), KEY_W'(want.ovf));
            end
        end
    end

    task automatic add_row(input logic signed [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                           input logic last, input bit typed, input t_sorted_res res);
        t_stim_row row;
        row.key   = key;
        row.tag   = tag;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    initial begin
        t_sorted_res none;
        t_stim_row   row;
        int          list_len;
        int          key_mode;
        int          pick;
        bit          no_idle;
        logic signed [KEY_W-1:0] key;

        none           = '0;
        start          = 1'b0;
        i_order_key    = '0;
        i_item_tag     = '0;
        i_last_in      = 1'b0;
        i_rst_n        = 1'b0;
        list_count     = 0;
        list_dropped   = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        lists_done     = 0;
        overflow_lists = 0;
        results_seen   = 0;
        entries_sent   = 0;

        // one-entry lists at the key extremes, straight after reset
        add_row(KEY_MAX, 4'hf, 1'b1, 1'b1, '{key: KEY_MAX, tag: 4'hf, last: 1'b1, ovf: 1'b0});
        add_row(KEY_MIN, 4'h0, 1'b1, 1'b1, '{key: KEY_MIN, tag: 4'h0, last: 1'b1, ovf: 1'b0});
        // equal keys must keep arrival order
        add_row(32'sd5, 4'h1, 1'b0, 1'b0, none);
        add_row(-32'sd1, 4'h2, 1'b0, 1'b0, none);
        add_row(32'sd5, 4'h3, 1'b0, 1'b0, none);
        add_row(32'sd0, 4'h4, 1'b0, 1'b0, none);
        add_row(32'sd5, 4'h5, 1'b1, 1'b0, none);
        // full list plus one more; the dropped entry carries the list end
        for (int i = 0; i <= MAX_ITEMS; i++) begin
            key = (i % 3 == 0) ? KEY_MIN + i : 32'(i * 7) - 32'sd40;
            add_row(key, TAG_W'(15 - i), (i == MAX_ITEMS), 1'b0, none);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_entry(row.key, row.tag, row.last, $urandom_range(0, MAX_GAP),
                       row.typed, row.res);
        end

        while (entries_sent < directed_rows.size() + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      list_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            else if (pick == 1) list_len = MAX_ITEMS;
            else if (pick == 2) list_len = 1;
            else                list_len = $urandom_range(2, MAX_ITEMS - 1);
            key_mode = $urandom_range(0, 2);
            no_idle  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < list_len; i++) begin
                case (key_mode)
                    0: key = $urandom;
                    1: key = $signed(32'($urandom_range(0, 6))) - 32'sd3;
                    default: begin
                        pick = $urandom_range(0, 4);
                        if (pick == 0)      key = KEY_MAX;
                        else if (pick == 1) key = KEY_MIN;
                        else if (pick == 2) key = 32'sd0;
                        else if (pick == 3) key = -32'sd1;
                        else                key = $urandom;
                    end
                endcase
                send_entry(key, TAG_W'($urandom), (i == list_len - 1),
                           no_idle ? 0 : $urandom_range(0, MAX_GAP), 1'b0, none);
            end
        end
        start     = 1'b0;
        i_last_in = 1'b0;

        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d entries in %0d lists (%0d overflowed), checked %0d sorted results",
                 entries_sent, lists_done, overflow_lists, results_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== stable_descending_key_sorter.f =====
hdl/sks_pkg.sv
hdl/sks_store.sv
hdl/stable_descending_key_sorter.sv
sim/stable_descending_key_sorter_test.sv
